/* hdl/bilateral_normal_smoother_assert.svh */
// Assertion macros for the bilateral normal smoother.
// Included by modules that carry concurrent checks; needs no package.
`ifndef BILATERAL_NORMAL_SMOOTHER_ASSERT_SVH
`define BILATERAL_NORMAL_SMOOTHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BNS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bns check failed");
`define BNS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bns check failed");
`else
`define BNS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BNS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hdl/bns_pkg.sv */
// Shared constants, types and exponential table builders for the smoother.
// No dependencies; used by the interfaces, controller, datapath and top level.
package bns_pkg;
   localparam int MAX_NEIGHBORS_DEF  = 64;
   localparam int EXP_TABLE_BITS_DEF = 10;

   localparam int CSR_INDEX_W = 8;
   localparam int COEFF_W     = 32;
   localparam logic [CSR_INDEX_W-1:0] REG_DIST_COEFF  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGLE_COEFF = 8'd1;
   localparam logic [COEFF_W-1:0]     COEFF_RESET     = 32'd65536;

   localparam int POS_W = 24;
   localparam int NRM_W = 16;
   localparam int ACC_W = 48;
   localparam int WGT_W = 27;
   localparam int TAB_W = 31;

   localparam int EXP_INT_LIMIT = 19;
   localparam int EXP_N_W       = 5;
   localparam logic [ACC_W-1:0] WEIGHT_THRESHOLD = 48'd67;

   localparam int DIV_STEPS = ACC_W;
   localparam int DIV_CNT_W = 6;
   localparam logic [1:0] AXIS_LAST = 2'd2;

   typedef logic [TAB_W-1:0] int_tab_type [EXP_INT_LIMIT];

   typedef struct packed {
      logic       item_load;
      logic       centre_load;
      logic       axis_step;
      logic [1:0] axis;
      logic       om_step;
      logic       prod_step;
      logic       esum_step;
      logic       rom_step;
      logic       wgt_step;
      logic       acc_step;
      logic       div_start;
      logic       div_step;
      logic       out_load;
      logic       out_quot;
   } dp_cmd_type;

   typedef struct packed {
      logic above_thresh;
   } dp_status_type;

   // exp(-x), x and result in Q.30, by a 25-term integer series
   function automatic logic [TAB_W-1:0] exp_neg_q30(input logic [63:0] x);
      logic signed [63:0] sum;
      logic [63:0]        term;
      sum  = 64'sd1073741824;
      term = 64'd1073741824;
      for (int n = 1; n <= 24; n++) begin
         term = ((term * x) >> 30) / 64'(n);
         if (n % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      if (sum > 64'sd1073741824) begin
         sum = 64'sd1073741824;
      end
      return TAB_W'(sum);
   endfunction

   function automatic int_tab_type build_int_exp();
      int_tab_type t;
      logic [63:0] e1;
      e1   = 64'(exp_neg_q30(64'd1073741824));
      t[0] = TAB_W'(64'd1073741824);
      for (int k = 1; k < EXP_INT_LIMIT; k++) begin
         t[k] = TAB_W'((64'(t[k-1]) * e1) >> 30);
      end
      return t;
   endfunction

   localparam int_tab_type INT_EXP = build_int_exp();
endpackage

/* hdl/bns_if.sv */
// Channel interfaces of the smoother: centre and neighbour items, results, register writes.
// Depends on bns_pkg for widths.
interface bns_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  opcode;
   logic signed [bns_pkg::POS_W-1:0]      pos_x;
   logic signed [bns_pkg::POS_W-1:0]      pos_y;
   logic signed [bns_pkg::POS_W-1:0]      pos_z;
   logic signed [bns_pkg::NRM_W-1:0]      norm_x;
   logic signed [bns_pkg::NRM_W-1:0]      norm_y;
   logic signed [bns_pkg::NRM_W-1:0]      norm_z;
   logic                                  last;
   modport source (output valid, opcode, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                   last, input ready);
   modport sink   (input valid, opcode, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                   last, output ready);
endinterface

interface bns_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [bns_pkg::NRM_W-1:0] out_x;
   logic signed [bns_pkg::NRM_W-1:0] out_y;
   logic signed [bns_pkg::NRM_W-1:0] out_z;
   logic                             updated;
   modport source (output valid, out_x, out_y, out_z, updated, input ready);
   modport sink   (input valid, out_x, out_y, out_z, updated, output ready);
endinterface

interface bns_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bns_pkg::CSR_INDEX_W-1:0]     index;
   logic [bns_pkg::COEFF_W-1:0]         data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/bns_ctrl.sv */
// Sequencing controller: steps one item through the datapath, runs the divider.
// Depends on bns_pkg and bilateral_normal_smoother_assert.svh.
`include "bilateral_normal_smoother_assert.svh"
module bns_ctrl #(
   parameter int MAX_NEIGHBORS = bns_pkg::MAX_NEIGHBORS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_opcode,
   input  logic                   req_last,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output bns_pkg::dp_cmd_type    cmd,
   input  bns_pkg::dp_status_type status
);
   localparam int NB_W = $clog2(MAX_NEIGHBORS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_AXIS, ST_OMEGA, ST_PROD, ST_ESUM, ST_ROM, ST_WGT, ST_ACCUM,
      ST_CHECK, ST_DIV, ST_EMIT
   } state_type;

   state_type                      state_ff, state_in;
   logic [1:0]                     axis_ff, axis_in;
   logic [bns_pkg::DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [NB_W-1:0]                nb_count_ff, nb_count_in;
   logic                           last_ff, last_in;
   logic                           quot_ff, quot_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      div_cnt_in   = div_cnt_ff;
      nb_count_in  = nb_count_ff;
      last_in      = last_ff;
      quot_in      = quot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.axis     = axis_ff;
      cmd.out_quot = quot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.item_load = 1'b1;
               last_in       = req_last;
               if (!req_opcode) begin
                  cmd.centre_load = 1'b1;
                  nb_count_in     = '0;
                  state_in        = ST_CHECK;
               end else if (nb_count_ff < NB_W'(MAX_NEIGHBORS)) begin
                  nb_count_in = nb_count_ff + NB_W'(1);
                  axis_in     = '0;
                  state_in    = ST_AXIS;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_AXIS: begin
            cmd.axis_step = 1'b1;
            if (axis_ff == bns_pkg::AXIS_LAST) begin
               state_in = ST_OMEGA;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_OMEGA: begin
            cmd.om_step = 1'b1;
            state_in    = ST_PROD;
         end
         ST_PROD: begin
            cmd.prod_step = 1'b1;
            state_in      = ST_ESUM;
         end
         ST_ESUM: begin
            cmd.esum_step = 1'b1;
            state_in      = ST_ROM;
         end
         ST_ROM: begin
            cmd.rom_step = 1'b1;
            state_in     = ST_WGT;
         end
         ST_WGT: begin
            cmd.wgt_step = 1'b1;
            state_in     = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.acc_step = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (status.above_thresh) begin
               cmd.div_start = 1'b1;
               div_cnt_in    = '0;
               state_in      = ST_DIV;
            end else begin
               quot_in  = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == bns_pkg::DIV_CNT_W'(bns_pkg::DIV_STEPS - 1)) begin
               quot_in  = 1'b1;
               state_in = ST_EMIT;
            end else begin
               div_cnt_in = div_cnt_ff + bns_pkg::DIV_CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         div_cnt_ff   <= '0;
         nb_count_ff  <= '0;
         last_ff      <= 1'b0;
         quot_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         div_cnt_ff   <= div_cnt_in;
         nb_count_ff  <= nb_count_in;
         last_ff      <= last_in;
         quot_ff      <= quot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `BNS_ASSERT_IMP(a_nb_bound, clock, reset, 1'b1, nb_count_ff <= NB_W'(MAX_NEIGHBORS))
   `BNS_ASSERT_NEXT(a_centre_clr, clock, reset, req_valid && req_ready && !req_opcode, nb_count_ff == '0)
   `BNS_ASSERT_IMP(a_div_last, clock, reset, state_ff == ST_DIV, last_ff)
endmodule

/* hdl/bns_datapath.sv */
// Arithmetic of the smoother: weight, accumulators, three divider lanes, result.
// Depends on bns_pkg; driven by bns_ctrl commands.
module bns_datapath #(
   parameter int EXP_TABLE_BITS = bns_pkg::EXP_TABLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bns_pkg::dp_cmd_type                 cmd,
   output bns_pkg::dp_status_type              status,
   input  logic                                csr_valid,
   input  logic [bns_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bns_pkg::COEFF_W-1:0]         csr_data,
   input  logic signed [bns_pkg::POS_W-1:0]    pos_x,
   input  logic signed [bns_pkg::POS_W-1:0]    pos_y,
   input  logic signed [bns_pkg::POS_W-1:0]    pos_z,
   input  logic signed [bns_pkg::NRM_W-1:0]    norm_x,
   input  logic signed [bns_pkg::NRM_W-1:0]    norm_y,
   input  logic signed [bns_pkg::NRM_W-1:0]    norm_z,
   output logic signed [bns_pkg::NRM_W-1:0]    out_x,
   output logic signed [bns_pkg::NRM_W-1:0]    out_y,
   output logic signed [bns_pkg::NRM_W-1:0]    out_z,
   output logic                                updated
);
   localparam int FRAC_DEPTH = 1 << EXP_TABLE_BITS;
   localparam int ACC_W = bns_pkg::ACC_W;
   localparam int TAB_W = bns_pkg::TAB_W;
   localparam int WGT_W = bns_pkg::WGT_W;

   typedef logic [TAB_W-1:0] frac_tab_type [FRAC_DEPTH];

   function automatic frac_tab_type build_frac();
      frac_tab_type t;
      for (int k = 0; k < FRAC_DEPTH; k++) begin
         t[k] = bns_pkg::exp_neg_q30(64'(k) << (30 - EXP_TABLE_BITS));
      end
      return t;
   endfunction

   localparam frac_tab_type FRAC_TAB = build_frac();

   logic [bns_pkg::COEFF_W-1:0]         dist_coeff_ff, angle_coeff_ff;
   logic signed [bns_pkg::POS_W-1:0]    in_pos [3];
   logic signed [bns_pkg::NRM_W-1:0]    in_nrm [3];
   logic signed [bns_pkg::POS_W-1:0]    cpos_ff [3];
   logic signed [bns_pkg::NRM_W-1:0]    cnrm_ff [3];
   logic signed [bns_pkg::POS_W-1:0]    pos_ff [3];
   logic signed [bns_pkg::NRM_W-1:0]    nrm_ff [3];

   logic signed [33:0]                  dot_ff, dot_in;
   logic [49:0]                         d2_ff, d2_in;
   logic [20:0]                         sq_ff;
   logic [52:0]                         ea_ff;
   logic [65:0]                         ed_ff;
   logic                                big_ff;
   logic [bns_pkg::EXP_N_W-1:0]         n_ff;
   logic [EXP_TABLE_BITS-1:0]           idx_ff;
   logic [TAB_W-1:0]                    int_q_ff, frac_q_ff;
   logic [WGT_W-1:0]                    w_ff, w_in;
   logic [ACC_W-1:0]                    wacc_ff, wacc_in;
   logic signed [ACC_W-1:0]             nacc_ff [3];
   logic signed [ACC_W-1:0]             nacc_in [3];

   logic [ACC_W-1:0]                    quo_ff [3];
   logic [ACC_W-1:0]                    rem_ff [3];
   logic                                neg_ff [3];
   logic [ACC_W-1:0]                    quo_in [3];
   logic [ACC_W-1:0]                    rem_in [3];
   logic [ACC_W-1:0]                    mag [3];
   logic signed [bns_pkg::NRM_W-1:0]    qsat [3];
   logic signed [bns_pkg::NRM_W-1:0]    out_ff [3];
   logic                                updated_ff;

   logic signed [24:0]                  diff_ax;
   logic signed [31:0]                  dot_term;
   logic signed [49:0]                  sqr_full;
   logic signed [34:0]                  om_num, om_adj;
   logic signed [19:0]                  om;
   logic signed [39:0]                  om_sq;
   logic [66:0]                         e_sum;
   logic [34:0]                         n_full;
   logic                                big;
   logic [61:0]                         w_prod;
   logic [WGT_W-1:0]                    w_raw;
   logic [ACC_W:0]                      wacc_sum;

   assign in_pos[0] = pos_x;
   assign in_pos[1] = pos_y;
   assign in_pos[2] = pos_z;
   assign in_nrm[0] = norm_x;
   assign in_nrm[1] = norm_y;
   assign in_nrm[2] = norm_z;

   always_comb begin
      diff_ax  = 25'(cpos_ff[cmd.axis]) - 25'(pos_ff[cmd.axis]);
      dot_term = 32'(cnrm_ff[cmd.axis]) * 32'(nrm_ff[cmd.axis]);
      sqr_full = 50'(diff_ax) * 50'(diff_ax);
      if (cmd.axis == '0) begin
         dot_in = 34'(dot_term);
         d2_in  = $unsigned(sqr_full);
      end else begin
         dot_in = dot_ff + 34'(dot_term);
         d2_in  = d2_ff + $unsigned(sqr_full);
      end
      om_num = 35'sh40000000 - 35'(dot_ff);
      om_adj = om_num + (om_num[34] ? 35'sd32767 : 35'sd0);
      om     = 20'(om_adj >>> 15);
      om_sq  = 40'(om) * 40'(om);
      e_sum  = 67'(ea_ff) + 67'(ed_ff);
      n_full = e_sum[66:32];
      big    = (n_full >= 35'(bns_pkg::EXP_INT_LIMIT));
      w_prod = 62'(int_q_ff) * 62'(frac_q_ff);
      w_raw  = w_prod[60:34];
      w_in   = (big_ff || w_raw == '0) ? WGT_W'(1) : w_raw;
      wacc_sum = (ACC_W+1)'(wacc_ff) + (ACC_W+1)'(w_ff);
      wacc_in  = wacc_sum[ACC_W] ? '1 : wacc_sum[ACC_W-1:0];
   end

   always_comb begin
      logic signed [43:0]      nprod;
      logic signed [ACC_W:0]   nsum;
      logic [ACC_W:0]          rshift;
      for (int i = 0; i < 3; i++) begin
         nprod = 44'($signed({1'b0, w_ff})) * 44'(nrm_ff[i]);
         nsum  = (ACC_W+1)'(nacc_ff[i]) + (ACC_W+1)'(nprod);
         if (nsum[ACC_W] != nsum[ACC_W-1]) begin
            nacc_in[i] = nsum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
         end else begin
            nacc_in[i] = nsum[ACC_W-1:0];
         end
         mag[i] = nacc_ff[i][ACC_W-1] ? ACC_W'(-nacc_ff[i]) : nacc_ff[i];
         rshift = {rem_ff[i], quo_ff[i][ACC_W-1]};
         if (rshift >= {1'b0, wacc_ff}) begin
            rem_in[i] = ACC_W'(rshift - {1'b0, wacc_ff});
            quo_in[i] = {quo_ff[i][ACC_W-2:0], 1'b1};
         end else begin
            rem_in[i] = rshift[ACC_W-1:0];
            quo_in[i] = {quo_ff[i][ACC_W-2:0], 1'b0};
         end
         if (!neg_ff[i]) begin
            qsat[i] = (|quo_ff[i][ACC_W-1:15]) ? 16'sh7fff : $signed(quo_ff[i][15:0]);
         end else if (quo_ff[i] > ACC_W'(32768)) begin
            qsat[i] = 16'sh8000;
         end else begin
            qsat[i] = $signed(~quo_ff[i][15:0] + 16'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_coeff_ff  <= bns_pkg::COEFF_RESET;
         angle_coeff_ff <= bns_pkg::COEFF_RESET;
      end else if (csr_valid) begin
         if (csr_index == bns_pkg::REG_DIST_COEFF) begin
            dist_coeff_ff <= csr_data;
         end else if (csr_index == bns_pkg::REG_ANGLE_COEFF) begin
            angle_coeff_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            cpos_ff[i] <= '0;
            cnrm_ff[i] <= '0;
            nacc_ff[i] <= '0;
         end
         wacc_ff <= '0;
      end else if (cmd.centre_load) begin
         for (int i = 0; i < 3; i++) begin
            cpos_ff[i] <= in_pos[i];
            cnrm_ff[i] <= in_nrm[i];
            nacc_ff[i] <= '0;
         end
         wacc_ff <= '0;
      end else if (cmd.acc_step) begin
         for (int i = 0; i < 3; i++) begin
            nacc_ff[i] <= nacc_in[i];
         end
         wacc_ff <= wacc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= in_pos[i];
            nrm_ff[i] <= in_nrm[i];
         end
      end
      if (cmd.axis_step) begin
         dot_ff <= dot_in;
         d2_ff  <= d2_in;
      end
      if (cmd.om_step) begin
         sq_ff <= om_sq[34:14];
      end
      if (cmd.prod_step) begin
         ea_ff <= 53'(angle_coeff_ff) * 53'(sq_ff);
         ed_ff <= 66'(dist_coeff_ff) * 66'(d2_ff[49:16]);
      end
      if (cmd.esum_step) begin
         big_ff <= big;
         n_ff   <= big ? '0 : n_full[bns_pkg::EXP_N_W-1:0];
         idx_ff <= e_sum[31:32-EXP_TABLE_BITS];
      end
      if (cmd.rom_step) begin
         frac_q_ff <= FRAC_TAB[idx_ff];
         int_q_ff  <= bns_pkg::INT_EXP[n_ff];
      end
      if (cmd.wgt_step) begin
         w_ff <= w_in;
      end
      for (int i = 0; i < 3; i++) begin
         if (cmd.div_start) begin
            quo_ff[i] <= mag[i];
            rem_ff[i] <= '0;
            neg_ff[i] <= nacc_ff[i][ACC_W-1];
         end else if (cmd.div_step) begin
            quo_ff[i] <= quo_in[i];
            rem_ff[i] <= rem_in[i];
         end
      end
      if (cmd.out_load) begin
         for (int i = 0; i < 3; i++) begin
            out_ff[i] <= cmd.out_quot ? qsat[i] : cnrm_ff[i];
         end
         updated_ff <= cmd.out_quot;
      end
   end

   assign status.above_thresh = (wacc_ff > bns_pkg::WEIGHT_THRESHOLD);
   assign out_x   = out_ff[0];
   assign out_y   = out_ff[1];
   assign out_z   = out_ff[2];
   assign updated = updated_ff;
endmodule

/* hdl/bilateral_normal_smoother.sv */
// Top level of the bilateral normal smoother: channels, controller, datapath.
// Depends on bns_pkg, bns_if, bns_ctrl and bns_datapath.
//
// Use: send a centre item (opcode 0) with the point's position and normal,
// then its neighbour items (opcode 1), the final one with last set. Each
// neighbour adds exp(-E) and that weight times its normal to the sums; on
// last one result item leaves on rsp_ch: sum over weight per component with
// updated = 1, or the centre normal with updated = 0 when the weight sum is
// too small. Neighbours past MAX_NEIGHBORS in a group add nothing.
// Order: a centre item is loaded, then checked; a neighbour takes three axis
// steps, then omega, product, exponent sum, registered table read, weight
// and accumulate steps. A result above the weight threshold first runs the
// three shared-denominator bit-serial divider lanes, then loads the output register.
// csr_ch is always ready; write the coefficients only while idle.
// Reset clears centre, sums and counts and sets both coefficients to 1.0.
// A stalled receiver holds the result in the output register; the next item
// is still taken and held only when its own result must wait.
module bilateral_normal_smoother #(
   parameter int MAX_NEIGHBORS  = bns_pkg::MAX_NEIGHBORS_DEF,
   parameter int EXP_TABLE_BITS = bns_pkg::EXP_TABLE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bns_req_if.sink   req_ch,
   bns_rsp_if.source rsp_ch,
   bns_csr_if.sink   csr_ch
);
   bns_pkg::dp_cmd_type    cmd;
   bns_pkg::dp_status_type status;

   assign csr_ch.ready = 1'b1;

   bns_ctrl #(
      .MAX_NEIGHBORS (MAX_NEIGHBORS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_last   (req_ch.last),
      .req_ready  (req_ch.ready),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .cmd        (cmd),
      .status     (status)
   );

   bns_datapath #(
      .EXP_TABLE_BITS (EXP_TABLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .pos_x     (req_ch.pos_x),
      .pos_y     (req_ch.pos_y),
      .pos_z     (req_ch.pos_z),
      .norm_x    (req_ch.norm_x),
      .norm_y    (req_ch.norm_y),
      .norm_z    (req_ch.norm_z),
      .out_x     (rsp_ch.out_x),
      .out_y     (rsp_ch.out_y),
      .out_z     (rsp_ch.out_z),
      .updated   (rsp_ch.updated)
   );
endmodule
